// ===== rtl/mpi_pkg.sv =====
// ----------------------------------------------------------------------------
// mpi_pkg: shared types and constants for the modular power / inverse core
// widths of the operands, reset modulus, operation codes, sequencer states,
// multiplier bus
// ----------------------------------------------------------------------------
package mpi_pkg;

  // modulus width used by the arithmetic (8 .. 32)
  localparam int MOD_BITS = 31;
  // exponent bits walked by the square and multiply loop (8 .. 64)
  localparam int EXP_BITS = 32;
  // width of the base and of the second multiplier operand
  localparam int BASE_BITS = 32;
  // width of the exponent port
  localparam int EXPIN_BITS = 32;
  // width of the modulus register and of the result port
  localparam int CFG_BITS = 31;
  localparam int RES_BITS = 31;

  localparam logic [CFG_BITS-1:0] MODULUS_RESET = CFG_BITS'(1000000009);

  // operation carried by in_kind
  typedef enum logic {
    OP_POWER   = 1'b0,
    OP_INVERSE = 1'b1
  } op_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_RED_WAIT,
    S_GCD,
    S_GCD_WAIT,
    S_EXP,
    S_SQ_WAIT,
    S_MUL,
    S_MUL_WAIT,
    S_DONE
  } mpi_state_t;

  typedef struct packed {
    logic                 start;
    logic [MOD_BITS-1:0]  a;
    logic [BASE_BITS-1:0] b;
    logic [MOD_BITS-1:0]  m;
  } mpi_mul_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MOD_BITS-1:0] r;
  } mpi_mul_rsp_t;

endpackage

// ===== rtl/mpi_mulmod.sv =====
// ----------------------------------------------------------------------------
// mpi_mulmod: bit-serial modular multiplier
// computes (a * b) mod m one bit of b per cycle, msb first; a < m required
// ----------------------------------------------------------------------------
module mpi_mulmod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpi_pkg::mpi_mul_req_t req,
  output mpi_pkg::mpi_mul_rsp_t rsp
);

  localparam int CW = $clog2(mpi_pkg::BASE_BITS + 1);
  localparam int W  = mpi_pkg::MOD_BITS + 2;

  logic [mpi_pkg::MOD_BITS-1:0]  acc_r, acc_nxt;
  logic [mpi_pkg::MOD_BITS-1:0]  a_r, a_nxt;
  logic [mpi_pkg::BASE_BITS-1:0] b_r, b_nxt;
  logic [mpi_pkg::MOD_BITS-1:0]  m_r, m_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;

  logic [W-1:0] t;
  logic [W-1:0] m1;
  logic [W-1:0] m2;
  logic [W-1:0] red;

  // acc < m and a < m, so 2*acc + a < 3m
  always_comb begin
    m1 = W'(m_r);
    m2 = m1 << 1;
    t  = (W'(acc_r) << 1) + (b_r[mpi_pkg::BASE_BITS-1] ? W'(a_r) : '0);
    if (t >= m2) begin
      red = t - m2;
    end else if (t >= m1) begin
      red = t - m1;
    end else begin
      red = t;
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      m_nxt    = req.m;
      cnt_nxt  = CW'(mpi_pkg::BASE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = red[mpi_pkg::MOD_BITS-1:0];
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.r    = acc_r;

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("mulmod busy with empty bit counter");

  a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> acc_r < m_r)
    else $error("mulmod result not reduced");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("mulmod done while still busy");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CW'(1) && !req.start) |=> done_r)
    else $error("mulmod missed done after last step");

endmodule

// ===== rtl/modular_power_inverse_core.sv =====
// ----------------------------------------------------------------------------
// modular_power_inverse_core: modular exponentiation and fermat inverse
// Each input transaction asks for base^exponent mod modulus (kind 0) or for
// the inverse of base mod modulus (kind 1), using the modulus held in the
// configuration register (reset 1000000009). The block takes one transaction
// at a time: in_ready is high only while the sequencer is idle, and the
// result sits in an output register so a new transaction can be taken while
// it waits. All arithmetic runs through one bit-serial modular multiplier
// that takes an issue, handles one bit of its 32-bit second operand per
// cycle and then signals done. A power transaction costs one reduction of
// the base plus one squaring per exponent bit below the top set bit and
// one multiply per further set bit. An inverse transaction also reduces
// the base, then runs euclid's gcd with one multiplier operation per
// remainder step (up to about 45 steps for a 31-bit modulus), then the
// power with exponent modulus-2, at most 30 squarings and 30 multiplies.
// A gcd other than 1 gives result 0 with out_no_inverse set. A modulus
// below two gives result 0 and out_no_inverse equal to kind.
// The inverse is correct only for a prime modulus. Configuration writes go
// straight to the register and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module modular_power_inverse_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [mpi_pkg::BASE_BITS-1:0]   in_base,
  input  logic [mpi_pkg::EXPIN_BITS-1:0]  in_exponent,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpi_pkg::RES_BITS-1:0]    out_result,
  output logic                            out_no_inverse,
  // configuration port
  input  logic                            cfg_we,
  input  logic [mpi_pkg::CFG_BITS-1:0]    cfg_wdata
);

  localparam int MB  = mpi_pkg::MOD_BITS;
  localparam int EB  = mpi_pkg::EXP_BITS;
  localparam int ECW = $clog2(EB + 1);
  // helper widths for zero extension followed by truncation
  localparam int MX  = (mpi_pkg::CFG_BITS > MB) ? mpi_pkg::CFG_BITS : MB;
  localparam int XI  = (mpi_pkg::EXPIN_BITS > EB) ? mpi_pkg::EXPIN_BITS : EB;
  localparam int XM  = (MB > EB) ? MB : EB;
  localparam int XR  = (MB > mpi_pkg::RES_BITS) ? MB : mpi_pkg::RES_BITS;

  mpi_pkg::mpi_state_t state_r, state_nxt;

  logic [mpi_pkg::CFG_BITS-1:0]  modulus_r;
  logic                          kind_r, kind_nxt;
  logic [mpi_pkg::BASE_BITS-1:0] base_r, base_nxt;
  logic [EB-1:0]                 exp_r, exp_nxt;
  logic [ECW-1:0]                ecnt_r, ecnt_nxt;
  logic [MB-1:0]                 br_r, br_nxt;       // base mod m
  logic [MB-1:0]                 ga_r, ga_nxt;       // euclid pair
  logic [MB-1:0]                 gb_r, gb_nxt;
  logic [MB-1:0]                 acc_r, acc_nxt;     // power accumulator
  logic                          started_r, started_nxt;
  logic [MB-1:0]                 res_r, res_nxt;
  logic                          flag_r, flag_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [mpi_pkg::RES_BITS-1:0]  out_result_r, out_result_nxt;
  logic                          out_no_inverse_r, out_no_inverse_nxt;

  mpi_pkg::mpi_mul_req_t req;
  mpi_pkg::mpi_mul_rsp_t rsp;

  logic [MX-1:0] mod_ext;
  logic [MB-1:0] m;
  logic          m_small;
  logic [XI-1:0] exp_in_ext;
  logic [XM-1:0] exp_inv_ext;
  logic [XR-1:0] res_ext;
  logic          in_acc;
  logic          out_free;
  logic          exp_bit;

  // effective modulus and derived operands
  always_comb begin
    mod_ext     = MX'(modulus_r);
    m           = mod_ext[MB-1:0];
    m_small     = m < MB'(2);
    exp_in_ext  = XI'(in_exponent);
    exp_inv_ext = XM'(m - MB'(2));
    res_ext     = XR'(res_r);
    exp_bit     = exp_r[EB-1];
  end

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // shared multiplier
  mpi_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpi_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = m_small ? mpi_pkg::S_DONE : mpi_pkg::S_RED;
        end
      end
      mpi_pkg::S_RED: begin
        state_nxt = mpi_pkg::S_RED_WAIT;
      end
      mpi_pkg::S_RED_WAIT: begin
        if (rsp.done) begin
          state_nxt = (kind_r == mpi_pkg::OP_INVERSE) ? mpi_pkg::S_GCD : mpi_pkg::S_EXP;
        end
      end
      mpi_pkg::S_GCD: begin
        if (ga_r == '0) begin
          state_nxt = (gb_r == MB'(1)) ? mpi_pkg::S_EXP : mpi_pkg::S_DONE;
        end else if (ga_r == MB'(1)) begin
          state_nxt = mpi_pkg::S_EXP;
        end else begin
          state_nxt = mpi_pkg::S_GCD_WAIT;
        end
      end
      mpi_pkg::S_GCD_WAIT: begin
        if (rsp.done) begin
          state_nxt = mpi_pkg::S_GCD;
        end
      end
      mpi_pkg::S_EXP: begin
        if (ecnt_r == '0) begin
          state_nxt = mpi_pkg::S_DONE;
        end else if (started_r) begin
          state_nxt = mpi_pkg::S_SQ_WAIT;
        end
      end
      mpi_pkg::S_SQ_WAIT: begin
        if (rsp.done) begin
          state_nxt = exp_bit ? mpi_pkg::S_MUL : mpi_pkg::S_EXP;
        end
      end
      mpi_pkg::S_MUL: begin
        state_nxt = mpi_pkg::S_MUL_WAIT;
      end
      mpi_pkg::S_MUL_WAIT: begin
        if (rsp.done) begin
          state_nxt = mpi_pkg::S_EXP;
        end
      end
      mpi_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mpi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mpi_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs: handshake and multiplier issue
  always_comb begin
    in_ready  = 1'b0;
    req.start = 1'b0;
    req.a     = MB'(1);
    req.b     = mpi_pkg::BASE_BITS'(acc_r);
    req.m     = m;
    case (state_r)
      mpi_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      mpi_pkg::S_RED: begin
        // base mod m as 1 * base
        req.start = 1'b1;
        req.b     = base_r;
      end
      mpi_pkg::S_GCD: begin
        // gb mod ga as 1 * gb under modulus ga
        req.start = (ga_r > MB'(1));
        req.b     = mpi_pkg::BASE_BITS'(gb_r);
        req.m     = ga_r;
      end
      mpi_pkg::S_EXP: begin
        // squaring
        req.start = (ecnt_r != '0) && started_r;
        req.a     = acc_r;
      end
      mpi_pkg::S_MUL: begin
        req.start = 1'b1;
        req.a     = acc_r;
        req.b     = mpi_pkg::BASE_BITS'(br_r);
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    kind_nxt           = kind_r;
    base_nxt           = base_r;
    exp_nxt            = exp_r;
    ecnt_nxt           = ecnt_r;
    br_nxt             = br_r;
    ga_nxt             = ga_r;
    gb_nxt             = gb_r;
    acc_nxt            = acc_r;
    started_nxt        = started_r;
    res_nxt            = res_r;
    flag_nxt           = flag_r;
    out_valid_nxt      = out_valid_r;
    out_result_nxt     = out_result_r;
    out_no_inverse_nxt = out_no_inverse_r;

    // result register drains on its own handshake
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mpi_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_nxt    = in_kind;
          base_nxt    = in_base;
          exp_nxt     = exp_in_ext[EB-1:0];
          ecnt_nxt    = ECW'(EB);
          acc_nxt     = MB'(1);
          started_nxt = 1'b0;
          res_nxt     = '0;
          // covers the small modulus case; cleared once an inverse exists
          flag_nxt    = (in_kind == mpi_pkg::OP_INVERSE);
        end
      end
      mpi_pkg::S_RED_WAIT: begin
        if (rsp.done) begin
          br_nxt = rsp.r;
          ga_nxt = rsp.r;
          gb_nxt = m;
          if (kind_r == mpi_pkg::OP_INVERSE) begin
            exp_nxt = exp_inv_ext[EB-1:0];
          end
        end
      end
      mpi_pkg::S_GCD: begin
        // gcd is 1: inverse exists
        if ((ga_r == '0 && gb_r == MB'(1)) || ga_r == MB'(1)) begin
          flag_nxt = 1'b0;
        end
      end
      mpi_pkg::S_GCD_WAIT: begin
        if (rsp.done) begin
          gb_nxt = ga_r;
          ga_nxt = rsp.r;
        end
      end
      mpi_pkg::S_EXP: begin
        if (ecnt_r == '0) begin
          res_nxt = acc_r;
        end else if (!started_r) begin
          // leading zero bits leave the accumulator at 1
          if (exp_bit) begin
            acc_nxt     = br_r;
            started_nxt = 1'b1;
          end
          exp_nxt  = exp_r << 1;
          ecnt_nxt = ecnt_r - ECW'(1);
        end
      end
      mpi_pkg::S_SQ_WAIT: begin
        if (rsp.done) begin
          acc_nxt = rsp.r;
          if (!exp_bit) begin
            exp_nxt  = exp_r << 1;
            ecnt_nxt = ecnt_r - ECW'(1);
          end
        end
      end
      mpi_pkg::S_MUL_WAIT: begin
        if (rsp.done) begin
          acc_nxt  = rsp.r;
          exp_nxt  = exp_r << 1;
          ecnt_nxt = ecnt_r - ECW'(1);
        end
      end
      mpi_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_result_nxt     = res_ext[mpi_pkg::RES_BITS-1:0];
          out_no_inverse_nxt = flag_r;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpi_pkg::S_IDLE;
      modulus_r   <= mpi_pkg::MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r           <= kind_nxt;
    base_r           <= base_nxt;
    exp_r            <= exp_nxt;
    ecnt_r           <= ecnt_nxt;
    br_r             <= br_nxt;
    ga_r             <= ga_nxt;
    gb_r             <= gb_nxt;
    acc_r            <= acc_nxt;
    started_r        <= started_nxt;
    res_r            <= res_nxt;
    flag_r           <= flag_nxt;
    out_result_r     <= out_result_nxt;
    out_no_inverse_r <= out_no_inverse_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_result     = out_result_r;
  assign out_no_inverse = out_no_inverse_r;

  a_no_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_no_inverse_r) |-> out_result_r == '0)
    else $error("no_inverse result carries a nonzero value");

  a_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !rsp.busy)
    else $error("multiplier issued while busy");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == mpi_pkg::S_RED_WAIT || state_r == mpi_pkg::S_GCD_WAIT ||
                  state_r == mpi_pkg::S_SQ_WAIT || state_r == mpi_pkg::S_MUL_WAIT))
    else $error("multiplier done outside a wait state");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the modular power / inverse core
// Drives power and inverse transactions over several modulus settings, with
// bursty input traffic and a stalling result consumer, and checks every
// result transaction against an in-order scoreboard that computes the
// expected residue and no-inverse flag itself.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HALF_PERIOD = 5;
  // several times the slowest legal run: ~260 transactions at the worst-case
  // inverse cost each, plus the longest sender gaps and receiver stalls
  localparam int TIMEOUT_NS = 100_000_000;
  localparam int RANDOM_ITEMS = 240;

  typedef struct {
    logic [mpi_pkg::RES_BITS-1:0] result;
    logic                         no_inverse;
  } residue_t;

  // in-order scoreboard: one expected residue per accepted operand
  class mpi_scoreboard;
    logic [mpi_pkg::CFG_BITS-1:0] modulus;
    residue_t                     residues_due[$];
    int                           errors;

    function new();
      modulus = mpi_pkg::MODULUS_RESET;
      errors  = 0;
    endfunction

    function void set_modulus(logic [mpi_pkg::CFG_BITS-1:0] value);
      modulus = value;
    endfunction

    function longint unsigned active_modulus();
      longint unsigned mask;
      mask = (mpi_pkg::MOD_BITS >= 32) ? 64'hFFFF_FFFF
                                       : ((64'd1 << mpi_pkg::MOD_BITS) - 64'd1);
      return longint'(modulus) & mask;
    endfunction

    // square and multiply, most significant exponent bit first
    function longint unsigned power_mod(longint unsigned b, longint unsigned e,
                                        longint unsigned m);
      longint unsigned acc;
      acc = 64'd1 % m;
      for (int i = mpi_pkg::EXP_BITS - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (i < 64 && ((e >> i) & 64'd1) != 0) begin
          acc = (acc * b) % m;
        end
      end
      return acc;
    endfunction

    function longint unsigned gcd(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (a != 0) begin
        t = b % a;
        b = a;
        a = t;
      end
      return b;
    endfunction

    function void note_operand(mpi_pkg::op_kind_t kind,
                               logic [mpi_pkg::BASE_BITS-1:0] base,
                               logic [mpi_pkg::EXPIN_BITS-1:0] exponent);
      longint unsigned m;
      longint unsigned b;
      longint unsigned res;
      residue_t        due;
      m   = active_modulus();
      res = 0;
      due.no_inverse = 1'b0;
      if (m < 2) begin
        // out of range modulus: zero result, flag follows the operation
        due.no_inverse = (kind == mpi_pkg::OP_INVERSE);
      end else begin
        b = longint'(base) % m;
        if (kind == mpi_pkg::OP_POWER) begin
          res = power_mod(b, longint'(exponent), m);
        end else if (gcd(b, m) != 1) begin
          due.no_inverse = 1'b1;
        end else begin
          // fermat inverse, only meaningful for a prime modulus
          res = power_mod(b, m - 2, m);
        end
      end
      due.result = mpi_pkg::RES_BITS'(res);
      residues_due.insert(residues_due.size(), due);
    endfunction

    function void check_result(logic [mpi_pkg::RES_BITS-1:0] result, logic no_inverse);
      residue_t due;
      if (residues_due.size() == 0) begin
        $error("result transaction with nothing pending: result %0d no_inverse %0b",
               result, no_inverse);
        errors++;
        return;
      end
      due = residues_due.pop_front();
      if (result !== due.result) begin
        $error("result mismatch: expected %0d actual %0d", due.result, result);
        errors++;
      end
      if (no_inverse !== due.no_inverse) begin
        $error("no_inverse mismatch: expected %0b actual %0b",
               due.no_inverse, no_inverse);
        errors++;
      end
    endfunction

    function int pending();
      return residues_due.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_kind = 1'b0;
  logic [mpi_pkg::BASE_BITS-1:0]  in_base = '0;
  logic [mpi_pkg::EXPIN_BITS-1:0] in_exponent = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mpi_pkg::RES_BITS-1:0]   out_result;
  logic                           out_no_inverse;
  logic                           cfg_we = 1'b0;
  logic [mpi_pkg::CFG_BITS-1:0]   cfg_wdata = '0;

  mpi_scoreboard sb = new();

  always #HALF_PERIOD clk = ~clk;

  modular_power_inverse_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_base        (in_base),
    .in_exponent    (in_exponent),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_no_inverse (out_no_inverse),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // result consumer: short and long stalls, with steady stretches in between
  int         rx_wait = 0;
  logic [11:0] rx_tick = '0;
  logic       rx_steady = 1'b1;

  always @(negedge clk) begin
    rx_tick <= rx_tick + 12'd1;
    if (rx_tick == '0) begin
      rx_steady <= ($urandom_range(0, 2) == 0);
    end
    if (rx_steady) begin
      out_ready <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      case ($urandom_range(0, 15))
        0, 1: rx_wait <= $urandom_range(1, 6);
        2: rx_wait <= $urandom_range(20, 120);
        default: ;
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_result, out_no_inverse);
    end
  end

  // one input transaction; called and returns at a falling edge, valid is left
  // high so a back-to-back transaction needs no second assignment
  task automatic push_operand(input mpi_pkg::op_kind_t kind,
                              input logic [mpi_pkg::BASE_BITS-1:0] base,
                              input logic [mpi_pkg::EXPIN_BITS-1:0] exponent);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_base     <= base;
    in_exponent <= exponent;
    do @(posedge clk); while (!in_ready);
    sb.note_operand(kind, base, exponent);
    @(negedge clk);
  endtask

  // wait for every pending result, then let the sequencer settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // only called with the core idle
  task automatic write_modulus(input logic [mpi_pkg::CFG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_modulus(value);
  endtask

  // bases mix full random values with residues near the modulus, multiples of
  // it and multiples of small factors so composite moduli hit gcd != 1
  function automatic logic [mpi_pkg::BASE_BITS-1:0] pick_base();
    longint unsigned m;
    m = sb.active_modulus();
    case ($urandom_range(0, 9))
      5: return $urandom_range(0, 40);
      6: return mpi_pkg::BASE_BITS'(longint'($urandom_range(0, 4)) * m);
      7: return mpi_pkg::BASE_BITS'(($urandom_range(0, 1) != 0) ? m + 1 : m - 1);
      8: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      9: return mpi_pkg::BASE_BITS'($urandom * $urandom_range(2, 6));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [mpi_pkg::EXPIN_BITS-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      6: return $urandom_range(0, 20);
      7: return '0;
      8: return '1;
      9: return mpi_pkg::EXPIN_BITS'($urandom) |
                {1'b1, {(mpi_pkg::EXPIN_BITS-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  // random transactions in bursts with gaps of widely varying length
  task automatic random_traffic(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 6);
      if (burst > left) burst = left;
      repeat (burst) begin
        push_operand(mpi_pkg::op_kind_t'($urandom_range(0, 1)), pick_base(),
                     pick_exponent());
        left--;
      end
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        3, 4, 5: gap = $urandom_range(1, 12);
        6: gap = $urandom_range(13, 200);
        default: gap = $urandom_range(200, 4000);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset modulus 1000000009
    push_operand(mpi_pkg::OP_POWER, 32'd0, 32'd0);
    push_operand(mpi_pkg::OP_POWER, 32'd0, 32'd5);
    push_operand(mpi_pkg::OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_operand(mpi_pkg::OP_POWER, 32'd2, 32'd10);
    push_operand(mpi_pkg::OP_POWER, 32'd1000000009, 32'd3);
    push_operand(mpi_pkg::OP_POWER, 32'd1000000010, 32'hFFFF_FFFF);
    push_operand(mpi_pkg::OP_POWER, 32'd12345, 32'd1);
    push_operand(mpi_pkg::OP_POWER, 32'h8000_0000, 32'h8000_0000);
    push_operand(mpi_pkg::OP_POWER, 32'd7, 32'h7FFF_FFFF);
    push_operand(mpi_pkg::OP_POWER, 32'h5555_5555, 32'hAAAA_AAAA);
    // base zero on inverse: gcd is the modulus itself
    push_operand(mpi_pkg::OP_INVERSE, 32'd0, 32'd0);
    push_operand(mpi_pkg::OP_INVERSE, 32'd1, 32'hFFFF_FFFF);
    push_operand(mpi_pkg::OP_INVERSE, 32'd2, 32'd0);
    push_operand(mpi_pkg::OP_INVERSE, 32'hFFFF_FFFF, 32'h1234_5678);
    push_operand(mpi_pkg::OP_INVERSE, 32'd1000000009, 32'd0);
    push_operand(mpi_pkg::OP_INVERSE, 32'd2000000018, 32'd0);
    push_operand(mpi_pkg::OP_INVERSE, 32'd1000000008, 32'd0);
    drain_results();

    // largest prime modulus
    write_modulus(31'h7FFF_FFFF);
    push_operand(mpi_pkg::OP_INVERSE, 32'h7FFF_FFFF, 32'd0);
    push_operand(mpi_pkg::OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_traffic(40);

    // smallest legal modulus
    write_modulus(31'd2);
    random_traffic(20);

    // modulus below two: zero result, flag equals the operation
    write_modulus(31'd1);
    random_traffic(10);
    write_modulus(31'd0);
    push_operand(mpi_pkg::OP_INVERSE, 32'd0, 32'd0);
    push_operand(mpi_pkg::OP_POWER, 32'd0, 32'd0);
    random_traffic(10);

    // composite modulus: many bases share a factor
    write_modulus(31'd360);
    random_traffic(40);

    write_modulus(31'd65537);
    random_traffic(40);

    write_modulus(31'($urandom));
    random_traffic(30);

    // back to the reset value through the port
    write_modulus(mpi_pkg::MODULUS_RESET);
    random_traffic(RANDOM_ITEMS - 190);

    // catch any stray result transaction
    repeat (64) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mpi_pkg.sv
rtl/mpi_mulmod.sv
rtl/modular_power_inverse_core.sv
dv/tb_top.sv
